FILE: hdl/iirdf1_pkg.sv
// Shared types and constants for the direct-form-I IIR filter core.
// No dependencies; used by every module in this folder.
package iirdf1_pkg;

	localparam int COEF_W = 32;
	localparam int HIST_W = 32;
	localparam int ACC_W  = 64;
	localparam int TAPS_W = 5;

	// Unity in Q7.24, the reset value of b0 and a0.
	localparam logic signed [COEF_W-1:0] ONE_Q24 = 32'sh0100_0000;

	// Item kinds carried in s_axis_tuser.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WR_B   = 2'd1;
	localparam logic [1:0] OP_WR_A   = 2'd2;

	// Configuration register indexes.
	localparam logic REG_FF_TAPS = 1'b0;
	localparam logic REG_FB_TAPS = 1'b1;

	// Contents of one cell: coefficient pair plus one slot of each history.
	typedef struct packed {
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
		logic signed [HIST_W-1:0] x;
		logic signed [HIST_W-1:0] y;
	} tap_t;

	// Commands broadcast to every cell.
	typedef struct packed {
		logic rotate;   // take neighbor i+1 contents (ring toward cell 0)
		logic shift_x;  // input history moves one slot away from cell 0
		logic shift_y;  // output history moves one slot away from cell 0
		logic clear;    // zero both histories
	} cell_ctl_t;

	// Multiply-accumulate controls.
	typedef struct packed {
		logic clr;
		logic vld;
		logic sub;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND,
		ST_EMIT
	} state_t;

endpackage

FILE: hdl/iirdf1_cell.sv
// One filter cell: b/a coefficient pair and one slot of each history.
// Depends on iirdf1_pkg.
module iirdf1_cell #(
	parameter bit UNITY_P = 1'b0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iirdf1_pkg::cell_ctl_t                ctl,
	input  logic                                 wr_b,
	input  logic                                 wr_a,
	input  logic signed [iirdf1_pkg::COEF_W-1:0] wr_data,
	input  iirdf1_pkg::tap_t                     rot_in,
	input  logic signed [iirdf1_pkg::HIST_W-1:0] x_in,
	input  logic signed [iirdf1_pkg::HIST_W-1:0] y_in,
	output iirdf1_pkg::tap_t                     tap
);

	localparam logic signed [iirdf1_pkg::COEF_W-1:0] COEF_RST =
		UNITY_P ? iirdf1_pkg::ONE_Q24 : '0;

	iirdf1_pkg::tap_t tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q.b <= COEF_RST;
			tap_q.a <= COEF_RST;
			tap_q.x <= '0;
			tap_q.y <= '0;
		end else if (ctl.rotate) begin
			tap_q <= rot_in;
		end else begin
			if (wr_b)
				tap_q.b <= wr_data;
			if (wr_a)
				tap_q.a <= wr_data;
			if (ctl.clear) begin
				tap_q.x <= '0;
				tap_q.y <= '0;
			end
			if (ctl.shift_x)
				tap_q.x <= x_in;
			if (ctl.shift_y)
				tap_q.y <= y_in;
		end
	end

	assign tap = tap_q;

endmodule

FILE: hdl/iirdf1_mac.sv
// Single multiply-accumulate unit at the head of the cell ring.
// Registered 32x32 product, then a 64-bit wrapping accumulator. Depends on iirdf1_pkg.
module iirdf1_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iirdf1_pkg::mac_ctl_t                 ctl,
	input  logic signed [iirdf1_pkg::COEF_W-1:0] coef,
	input  logic signed [iirdf1_pkg::HIST_W-1:0] data,
	output logic        [iirdf1_pkg::ACC_W-1:0]  acc
);

	logic signed [iirdf1_pkg::ACC_W-1:0] prod_s1;
	logic                                vld_s1;
	logic                                sub_s1;
	logic        [iirdf1_pkg::ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sub_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.vld;
			sub_s1 <= ctl.sub;
			if (ctl.clr)
				acc_q <= '0;
			else if (vld_s1) begin
				if (sub_s1)
					acc_q <= acc_q - prod_s1;
				else
					acc_q <= acc_q + prod_s1;
			end
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/iirdf1_core_top_note.sv
// Output code helper: maps a Q11.20 filter output to the 12-bit code and clip flag.
// Depends on iirdf1_pkg.
module iirdf1_coder (
	input  logic signed [iirdf1_pkg::HIST_W-1:0] y,
	output logic        [11:0]                   code,
	output logic                                 clip
);

	logic [23:0] v;
	logic        neg;
	logic        over;

	// floor(y / 2^9) + 2048, kept at 24 bits so the sign survives
	assign v    = {y[31], y[31:9]} + 24'd2048;
	assign neg  = v[23];
	assign over = !neg && ((v[22:12] != '0) || ((v[11:0] == 12'hFFF) && (y[8:0] != '0)));

	always_comb begin
		clip = neg || over;
		if (neg)
			code = 12'd0;
		else if (over)
			code = 12'hFFF;
		else
			code = v[11:0];
	end

endmodule

FILE: hdl/iir_direct_form_one_filter_core.sv
// Direct-form-I IIR filter core: 12-bit converter samples in, 12-bit output codes out.
// Depends on iirdf1_pkg, iirdf1_cell, iirdf1_mac, iirdf1_coder.
//
// User notes: each sample transaction (tuser = 0) produces one result transaction,
// y = sum b_k x[n-k] - sum(k>=1) a_k y[n-k], coded as floor((y+1)*2048) saturated
// to 0..4095 with tuser = 1 when clipped. Coefficients are Q7.24, history Q11.20,
// accumulation 64 bits wrapping, result rounded half up. A coefficient write
// (tuser = 1 for b, 2 for a) gives no result and clears both histories; an
// index above MAX_ORDER_P does nothing, and kind 3 is dropped.
// The state lives in a ring of MAX_ORDER_P+1 cells; per sample the ring turns
// twice past one multiplier at cell 0 (b*x pass, then a*y pass), and no other
// transaction is taken until the result code is loaded; the single multiplier
// makes the core serial. A finished code sits in an output register, so the
// input side reopens while it waits.
// Tap-count registers: 0 acts as 1, values above MAX_ORDER_P+1 act as the maximum;
// write them only while idle.
module iir_direct_form_one_filter_core #(
	parameter int MAX_ORDER_P = 20
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // sample[11:0], coef_index[16:12], coef_value[48:17], zero
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_code[11:0], zero
	output logic        m_axis_tuser,  // clipped[0]

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_wdata
);

	localparam int DEPTH = MAX_ORDER_P + 1;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (IW > iirdf1_pkg::TAPS_W) ? IW : iirdf1_pkg::TAPS_W;
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	// ---- input unpack ----
	logic [1:0]                           opcode;
	logic [11:0]                          sample;
	logic [4:0]                           coef_index;
	logic signed [iirdf1_pkg::COEF_W-1:0] coef_value;

	assign opcode     = s_axis_tuser;
	assign sample     = s_axis_tdata[11:0];
	assign coef_index = s_axis_tdata[16:12];
	assign coef_value = s_axis_tdata[48:17];

	// sample - 2048 is the sample with its top bit inverted; scale by 2^9 into Q11.20
	logic signed [11:0]                   x_c;
	logic signed [iirdf1_pkg::HIST_W-1:0] x_new;

	assign x_c   = {~sample[11], sample[10:0]};
	assign x_new = {{11{x_c[11]}}, x_c, 9'b0};

	// ---- configuration registers ----
	logic [iirdf1_pkg::TAPS_W-1:0] ff_taps_q;
	logic [iirdf1_pkg::TAPS_W-1:0] fb_taps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_taps_q <= iirdf1_pkg::TAPS_W'(1);
			fb_taps_q <= iirdf1_pkg::TAPS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				iirdf1_pkg::REG_FF_TAPS: ff_taps_q <= cfg_wdata;
				iirdf1_pkg::REG_FB_TAPS: fb_taps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---- sequencer ----
	iirdf1_pkg::state_t    state_q, state_d;
	logic [IW-1:0]         k_q, k_d;      // coefficient index now sitting in cell 0
	logic                  pass_q, pass_d; // 0: feedforward pass, 1: feedback pass
	iirdf1_pkg::cell_ctl_t cell_ctl;
	iirdf1_pkg::mac_ctl_t  mac_ctl;
	logic                  accept;
	logic                  idx_ok;
	logic                  wr_b_any;
	logic                  wr_a_any;
	logic                  round_load;
	logic                  out_load;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign idx_ok   = CW'(coef_index) <= CW'(MAX_ORDER_P);
	assign wr_b_any = accept && (opcode == iirdf1_pkg::OP_WR_B) && idx_ok;
	assign wr_a_any = accept && (opcode == iirdf1_pkg::OP_WR_A) && idx_ok;

	logic out_valid_q;

	always_comb begin
		state_d       = state_q;
		k_d           = k_q;
		pass_d        = pass_q;
		cell_ctl      = '0;
		mac_ctl       = '0;
		s_axis_tready = 1'b0;
		round_load    = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			iirdf1_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					unique case (opcode) inside
						iirdf1_pkg::OP_SAMPLE: begin
							cell_ctl.shift_x = 1'b1;
							mac_ctl.clr      = 1'b1;
							k_d              = '0;
							pass_d           = 1'b0;
							state_d          = iirdf1_pkg::ST_RUN;
						end
						iirdf1_pkg::OP_WR_B, iirdf1_pkg::OP_WR_A: begin
							cell_ctl.clear = idx_ok;
						end
						default: ;
					endcase
				end
			end
			iirdf1_pkg::ST_RUN: begin
				cell_ctl.rotate = 1'b1;
				mac_ctl.sub     = pass_q;
				// a0 never counts; a tap count of 0 behaves as 1
				if (pass_q)
					mac_ctl.vld = (k_q != '0) && (CW'(k_q) < CW'(fb_taps_q));
				else
					mac_ctl.vld = (k_q == '0) || (CW'(k_q) < CW'(ff_taps_q));
				if (k_q == LAST) begin
					k_d    = '0;
					pass_d = 1'b1;
					if (pass_q)
						state_d = iirdf1_pkg::ST_DRAIN;
				end else begin
					k_d = k_q + IW'(1);
				end
			end
			iirdf1_pkg::ST_DRAIN: begin
				// last product lands in the accumulator at this edge
				state_d = iirdf1_pkg::ST_ROUND;
			end
			iirdf1_pkg::ST_ROUND: begin
				round_load = 1'b1;
				state_d    = iirdf1_pkg::ST_EMIT;
			end
			iirdf1_pkg::ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					cell_ctl.shift_y = 1'b1;
					out_load         = 1'b1;
					state_d          = iirdf1_pkg::ST_IDLE;
				end
			end
			default: state_d = iirdf1_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirdf1_pkg::ST_IDLE;
			k_q     <= '0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			pass_q  <= pass_d;
		end
	end

	// ---- cell ring ----
	// Cell k holds b_k, a_k, x[n-k] and y[n-k]; cell 0's y slot stays zero.
	// Two full turns bring every cell back home.
	iirdf1_pkg::tap_t tap [DEPTH];
	logic signed [iirdf1_pkg::HIST_W-1:0] y_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                                 wr_b_i;
		logic                                 wr_a_i;
		logic signed [iirdf1_pkg::HIST_W-1:0] x_in_i;
		logic signed [iirdf1_pkg::HIST_W-1:0] y_in_i;

		assign wr_b_i = wr_b_any && (CW'(coef_index) == CW'(i));
		assign wr_a_i = wr_a_any && (CW'(coef_index) == CW'(i));

		if (i == 0) begin : g_head
			assign x_in_i = x_new;
			assign y_in_i = '0;
		end else if (i == 1) begin : g_second
			assign x_in_i = tap[i-1].x;
			assign y_in_i = y_q;
		end else begin : g_rest
			assign x_in_i = tap[i-1].x;
			assign y_in_i = tap[i-1].y;
		end

		iirdf1_cell #(
			.UNITY_P (i == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.wr_b    (wr_b_i),
			.wr_a    (wr_a_i),
			.wr_data (coef_value),
			.rot_in  (tap[(i + 1) % DEPTH]),
			.x_in    (x_in_i),
			.y_in    (y_in_i),
			.tap     (tap[i])
		);
	end

	// ---- multiply-accumulate at the head cell ----
	logic signed [iirdf1_pkg::COEF_W-1:0] mac_coef;
	logic signed [iirdf1_pkg::HIST_W-1:0] mac_data;
	logic        [iirdf1_pkg::ACC_W-1:0]  acc;

	assign mac_coef = pass_q ? tap[0].a : tap[0].b;
	assign mac_data = pass_q ? tap[0].y : tap[0].x;

	iirdf1_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.data   (mac_data),
		.acc    (acc)
	);

	// ---- round half up from Q.44 to Q11.20, saturate to 32 bits ----
	logic [40:0] y_round;

	assign y_round = {acc[63], acc[63:24]} + 41'(acc[23]);

	always_ff @(posedge clk) begin
		if (round_load) begin
			if (y_round[40:31] == {10{y_round[40]}})
				y_q <= y_round[31:0];
			else if (y_round[40])
				y_q <= 32'sh8000_0000;
			else
				y_q <= 32'sh7FFF_FFFF;
		end
	end

	// ---- output code and result register ----
	logic [11:0] code;
	logic        clip;
	logic [11:0] out_code_q;
	logic        clipped_q;

	iirdf1_coder u_coder (
		.y    (y_q),
		.code (code),
		.clip (clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_code_q <= code;
			clipped_q  <= clip;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_code_q};
	assign m_axis_tuser  = clipped_q;

	// ---- assertions ----
	a_sample_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == iirdf1_pkg::OP_SAMPLE))
		|=> (state_q == iirdf1_pkg::ST_RUN) && (k_q == '0) && !pass_q)
		else $error("sample transaction did not start the feedforward pass");

	a_two_turns: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == iirdf1_pkg::ST_RUN) && (k_q == LAST) && pass_q)
		|=> (state_q == iirdf1_pkg::ST_DRAIN))
		else $error("ring did not stop after two full turns");

	a_head_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iirdf1_pkg::ST_IDLE) |-> (tap[0].y == '0))
		else $error("head cell output slot not zero with ring at home");

	a_emit_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == iirdf1_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready))
		|=> m_axis_tvalid && (state_q == iirdf1_pkg::ST_IDLE))
		else $error("finished result not presented");

endmodule
